// ===== sv/i2cmts_pkg.sv =====
// Shared types, codes and constants of the I2C master transaction sequencer.
package i2cmts_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_STATUS = 2'd2,
    OP_POLL   = 2'd3
  } op_t;

  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  localparam int PF_READ  = 0;
  localparam int PF_WRITE = 1;
  localparam int PF_SEQ   = 2;
  localparam int PF_ERROR = 3;

  localparam logic [7:0] TIMEOUT_RESET = 8'h80;
  localparam logic       REG_TIMEOUT   = 1'b0;

  typedef struct packed {
    op_t        op;
    logic [6:0] dev_addr;
    logic [2:0] access_mode;
    logic [4:0] write_count;
    logic [4:0] read_count;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] last_status;
    logic       poll_event;
    logic [3:0] pending;
    logic [7:0] rd_byte;
    logic [3:0] rd_index;
    logic       rd_valid;
    logic       release_bus;
    logic [7:0] tx_byte;
    logic       load_tx;
    logic       drive_ack;
    logic       drive_stop;
    logic       drive_start;
  } out_item_t;

endpackage

// ===== sv/i2cmts_cfg.sv =====
// APB-style configuration register holding the busy timeout.
module i2cmts_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  busy_timeout
);

  logic [7:0] timeout_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == i2cmts_pkg::REG_TIMEOUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= i2cmts_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_r <= pwdata[7:0];
    end
  end

  assign prdata       = (paddr[2] == i2cmts_pkg::REG_TIMEOUT) ? {24'd0, timeout_r} : 32'd0;
  assign busy_timeout = timeout_r;

endmodule

// ===== sv/i2cmts_in_reg.sv =====
// Input register that captures one item ahead of the sequencing logic.
module i2cmts_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cmts_pkg::in_item_t in_item,
  input  logic                 advance,
  output logic                 item_valid,
  output i2cmts_pkg::in_item_t item
);

  logic                 valid_r;
  i2cmts_pkg::in_item_t item_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/i2cmts_core.sv =====
// Transfer state, write buffer and the per-item sequencing logic.
module i2cmts_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  i2cmts_pkg::in_item_t  item,
  input  logic [7:0]            busy_timeout,
  output i2cmts_pkg::out_item_t result
);

  logic [7:0] buf_r [i2cmts_pkg::BUF_DEPTH];
  logic [4:0] ptr_r, ptr_nxt;
  logic [3:0] pf_r, pf_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [4:0] send_r, send_nxt;
  logic [4:0] recv_r, recv_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] busy_r, busy_nxt;
  logic [7:0] buf_rd;
  logic       buf_wr;

  assign buf_wr = fire && (item.op == i2cmts_pkg::OP_LOAD) &&
                  (int'(item.load_index) < i2cmts_pkg::BUF_DEPTH);
  assign buf_rd = (int'(ptr_r) < i2cmts_pkg::BUF_DEPTH) ?
                  buf_r[ptr_r[i2cmts_pkg::BUF_AW-1:0]] : 8'd0;

  always_ff @(posedge clk) begin
    if (buf_wr) begin
      buf_r[item.load_index[i2cmts_pkg::BUF_AW-1:0]] <= item.load_byte;
    end
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    pf_nxt     = pf_r;
    addr_nxt   = addr_r;
    send_nxt   = send_r;
    recv_nxt   = recv_r;
    status_nxt = status_r;
    busy_nxt   = busy_r;
    result     = '0;
    unique case (item.op)
      i2cmts_pkg::OP_LOAD: begin
      end
      i2cmts_pkg::OP_START: begin
        if (!pf_r[i2cmts_pkg::PF_ERROR]) begin
          addr_nxt           = item.dev_addr;
          pf_nxt             = {1'b0, item.access_mode};
          send_nxt           = item.write_count;
          recv_nxt           = item.read_count;
          result.drive_start = 1'b1;
        end
      end
      i2cmts_pkg::OP_STATUS: begin
        status_nxt = item.bus_status;
        case (item.bus_status)
          i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START: begin
            ptr_nxt        = 5'd0;
            result.load_tx = 1'b1;
            result.tx_byte = {addr_r, !pf_r[i2cmts_pkg::PF_WRITE]};
          end
          i2cmts_pkg::ST_MT_SLA_ACK, i2cmts_pkg::ST_MT_DATA_ACK: begin
            if (ptr_r < send_r) begin
              result.load_tx = 1'b1;
              result.tx_byte = buf_rd;
              ptr_nxt        = ptr_r + 5'd1;
            end else begin
              result.drive_stop = !pf_r[i2cmts_pkg::PF_SEQ];
              pf_nxt[i2cmts_pkg::PF_WRITE] = 1'b0;
              pf_nxt[i2cmts_pkg::PF_SEQ]   = 1'b0;
              result.drive_start = pf_r[i2cmts_pkg::PF_READ];
            end
          end
          i2cmts_pkg::ST_MR_SLA_ACK: begin
            result.drive_ack = ({1'b0, ptr_r} + 6'd1) < {1'b0, recv_r};
          end
          i2cmts_pkg::ST_MR_DATA_ACK: begin
            result.rd_valid  = 1'b1;
            result.rd_index  = ptr_r[3:0];
            result.rd_byte   = item.rx_data;
            ptr_nxt          = ptr_r + 5'd1;
            result.drive_ack = ({1'b0, ptr_nxt} + 6'd1) < {1'b0, recv_r};
          end
          i2cmts_pkg::ST_MR_DATA_NACK: begin
            result.rd_valid   = 1'b1;
            result.rd_index   = ptr_r[3:0];
            result.rd_byte    = item.rx_data;
            ptr_nxt           = ptr_r + 5'd1;
            result.drive_stop = 1'b1;
            pf_nxt[i2cmts_pkg::PF_READ] = 1'b0;
          end
          i2cmts_pkg::ST_ARB_LOST: begin
            result.drive_start = 1'b1;
          end
          default: begin
            result.release_bus = 1'b1;
            pf_nxt[i2cmts_pkg::PF_ERROR] = 1'b1;
          end
        endcase
      end
      i2cmts_pkg::OP_POLL: begin
        if (pf_r == 4'd0) begin
          busy_nxt = 8'd0;
        end else begin
          busy_nxt = busy_r + 8'd1;
          if (busy_nxt == busy_timeout) begin
            pf_nxt            = 4'b1000;
            result.drive_stop = 1'b1;
            result.poll_event = 1'b1;
          end else if (busy_nxt == 8'd0) begin
            status_nxt        = 8'd0;
            pf_nxt            = 4'd0;
            result.poll_event = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    result.pending     = pf_nxt;
    result.last_status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= 5'd0;
      pf_r     <= 4'd0;
      addr_r   <= 7'd0;
      send_r   <= 5'd0;
      recv_r   <= 5'd0;
      status_r <= 8'd0;
      busy_r   <= 8'd0;
    end else if (fire) begin
      ptr_r    <= ptr_nxt;
      pf_r     <= pf_nxt;
      addr_r   <= addr_nxt;
      send_r   <= send_nxt;
      recv_r   <= recv_nxt;
      status_r <= status_nxt;
      busy_r   <= busy_nxt;
    end
  end

  a_release_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.release_bus |=> pf_r[i2cmts_pkg::PF_ERROR])
    else $error("Bus release did not set the error flag.");

  a_rd_only_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.rd_valid |-> item.op == i2cmts_pkg::OP_STATUS)
    else $error("Received byte delivered outside a status item.");

  a_start_ignored_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == i2cmts_pkg::OP_START && pf_r[i2cmts_pkg::PF_ERROR]
    |=> $stable(addr_r) && pf_r[i2cmts_pkg::PF_ERROR])
    else $error("Start request taken while the error flag was set.");

  a_ptr_advances_on_rx: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.rd_valid |=> ptr_r == $past(ptr_r) + 5'd1)
    else $error("Byte pointer did not advance on a received byte.");

endmodule

// ===== sv/i2cmts_out_reg.sv =====
// Result register that holds one finished item until the consumer takes it.
module i2cmts_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  i2cmts_pkg::out_item_t result,
  input  logic                  out_ready,
  output logic                  out_valid,
  output i2cmts_pkg::out_item_t out_item,
  output logic                  free
);

  logic                  valid_r;
  i2cmts_pkg::out_item_t item_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== sv/i2c_master_transaction_sequencer_unit.sv =====
// Top level of the I2C master transaction sequencer.
//
//   Channel  Direction  Handshake                Payload
//   in_      sink       in_tvalid / in_tready    in_tdata 48 bits, in_tuser = op
//   out_     source     out_tvalid / out_tready  out_tdata 40 bits
//   cfg_     APB slave  psel, penable, pready    busy_timeout at byte address 0
//
// Each item is held in the input register, then sequenced into the
// result register, so one item is taken per cycle while that register
// is free. Reset clears the transfer state and the handshake flags, and
// the timeout returns to 128. A stalled result holds the pipeline; the
// input register still takes one item while the result waits.
module i2c_master_transaction_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // dev_addr[6:0], access_mode[9:7], write_count[14:10], read_count[19:15],
  // load_index[23:20], load_byte[31:24], bus_status[39:32], rx_data[47:40]
  input  logic [47:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_start[0], drive_stop[1], drive_ack[2], load_tx[3], tx_byte[11:4],
  // release_bus[12], rd_valid[13], rd_index[17:14], rd_byte[25:18],
  // pending[29:26], poll_event[30], last_status[38:31], zero[39]
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  i2cmts_pkg::in_item_t  in_item;
  i2cmts_pkg::in_item_t  item;
  i2cmts_pkg::out_item_t result;
  i2cmts_pkg::out_item_t out_item;
  logic                  item_valid;
  logic                  out_free;
  logic                  advance;
  logic [7:0]            busy_timeout;

  always_comb begin
    in_item.op          = i2cmts_pkg::op_t'(in_tuser);
    in_item.dev_addr    = in_tdata[6:0];
    in_item.access_mode = in_tdata[9:7];
    in_item.write_count = in_tdata[14:10];
    in_item.read_count  = in_tdata[19:15];
    in_item.load_index  = in_tdata[23:20];
    in_item.load_byte   = in_tdata[31:24];
    in_item.bus_status  = in_tdata[39:32];
    in_item.rx_data     = in_tdata[47:40];
  end

  assign advance = item_valid && out_free;

  i2cmts_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .busy_timeout (busy_timeout)
  );

  i2cmts_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cmts_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .item         (item),
    .busy_timeout (busy_timeout),
    .result       (result)
  );

  i2cmts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (out_item),
    .free      (out_free)
  );

  assign out_tdata = {1'b0, out_item};

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the I2C master transaction sequencer unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int          IDLE_LIMIT   = 4000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PHASE_ITEMS  = 230;
  localparam logic [2:0]  TIMEOUT_ADDR = 3'(4 * i2cmts_pkg::REG_TIMEOUT);
  localparam logic [7:0]  KNOWN_CODES [8] = '{i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START,
                                              i2cmts_pkg::ST_MT_SLA_ACK,
                                              i2cmts_pkg::ST_MT_DATA_ACK,
                                              i2cmts_pkg::ST_ARB_LOST,
                                              i2cmts_pkg::ST_MR_SLA_ACK,
                                              i2cmts_pkg::ST_MR_DATA_ACK,
                                              i2cmts_pkg::ST_MR_DATA_NACK};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_master_transaction_sequencer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the sequencer state, advanced once per accepted item.
  logic [7:0] buf_img [i2cmts_pkg::BUF_DEPTH];
  logic [4:0] ptr = '0;
  logic [3:0] flags = '0;
  logic [6:0] addr7 = '0;
  logic [4:0] n_send = '0;
  logic [4:0] n_recv = '0;
  logic [7:0] status_last = '0;
  logic [7:0] ticks = '0;
  logic [7:0] timeout_val = i2cmts_pkg::TIMEOUT_RESET;

  i2cmts_pkg::in_item_t  req_q [$];
  i2cmts_pkg::out_item_t cmd_q [$];
  i2cmts_pkg::in_item_t  drv_item = '0;
  logic      drv_busy = 1'b0;
  int        gap_left = 0;
  int        burst_left = 0;
  int        items_in = 0;
  int        n_results = 0;
  int        errors = 0;
  int        pushed = 0;
  int        recoveries = 0;
  int        settings = 1;
  logic      cut = 1'b0;
  int        hold_left = 0;
  int        next_hold = 300;
  int        stall_mode = 0;
  int        cyc_cnt = 0;
  int        idle_cnt = 0;

  function automatic i2cmts_pkg::out_item_t expected_commands(input i2cmts_pkg::in_item_t it);
    i2cmts_pkg::out_item_t r;
    r = '0;
    case (it.op)
      i2cmts_pkg::OP_LOAD: buf_img[it.load_index] = it.load_byte;
      i2cmts_pkg::OP_START: begin
        if (!flags[i2cmts_pkg::PF_ERROR]) begin
          addr7 = it.dev_addr;
          flags = {1'b0, it.access_mode};
          n_send = it.write_count;
          n_recv = it.read_count;
          r.drive_start = 1'b1;
        end
      end
      i2cmts_pkg::OP_STATUS: begin
        status_last = it.bus_status;
        case (it.bus_status)
          i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START: begin
            ptr = '0;
            r.load_tx = 1'b1;
            r.tx_byte = {addr7, ~flags[i2cmts_pkg::PF_WRITE]};
          end
          i2cmts_pkg::ST_MT_SLA_ACK, i2cmts_pkg::ST_MT_DATA_ACK: begin
            if (ptr < n_send) begin
              r.load_tx = 1'b1;
              r.tx_byte = (int'(ptr) < i2cmts_pkg::BUF_DEPTH) ? buf_img[ptr[3:0]] : 8'h00;
              ptr = ptr + 5'd1;
            end else begin
              r.drive_stop = !flags[i2cmts_pkg::PF_SEQ];
              flags[i2cmts_pkg::PF_WRITE] = 1'b0;
              flags[i2cmts_pkg::PF_SEQ] = 1'b0;
              r.drive_start = flags[i2cmts_pkg::PF_READ];
            end
          end
          i2cmts_pkg::ST_MR_SLA_ACK, i2cmts_pkg::ST_MR_DATA_ACK: begin
            if (it.bus_status == i2cmts_pkg::ST_MR_DATA_ACK) begin
              r.rd_valid = 1'b1;
              r.rd_index = ptr[3:0];
              r.rd_byte = it.rx_data;
              ptr = ptr + 5'd1;
            end
            r.drive_ack = (6'(ptr) + 6'd1) < 6'(n_recv);
          end
          i2cmts_pkg::ST_MR_DATA_NACK: begin
            r.rd_valid = 1'b1;
            r.rd_index = ptr[3:0];
            r.rd_byte = it.rx_data;
            ptr = ptr + 5'd1;
            r.drive_stop = 1'b1;
            flags[i2cmts_pkg::PF_READ] = 1'b0;
          end
          i2cmts_pkg::ST_ARB_LOST: r.drive_start = 1'b1;
          default: begin
            r.release_bus = 1'b1;
            flags[i2cmts_pkg::PF_ERROR] = 1'b1;
          end
        endcase
      end
      default: begin
        if (flags == '0) begin
          ticks = '0;
        end else begin
          ticks = ticks + 8'd1;
          if (ticks == timeout_val) begin
            flags = '0;
            flags[i2cmts_pkg::PF_ERROR] = 1'b1;
            r.drive_stop = 1'b1;
            r.poll_event = 1'b1;
          end else if (ticks == '0) begin
            status_last = '0;
            flags = '0;
            r.poll_event = 1'b1;
          end
        end
      end
    endcase
    r.pending = flags;
    r.last_status = status_last;
    return r;
  endfunction

  task automatic check_result(input i2cmts_pkg::out_item_t got, input logic pad);
    i2cmts_pkg::out_item_t want;
    string     bad;
    n_results++;
    if (cmd_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result %h with nothing expected", got);
    end else begin
      want = cmd_q.pop_front();
      bad = "";
      if (got.drive_start !== want.drive_start) bad = {bad, " drive_start"};
      if (got.drive_stop !== want.drive_stop) bad = {bad, " drive_stop"};
      if (got.drive_ack !== want.drive_ack) bad = {bad, " drive_ack"};
      if (got.load_tx !== want.load_tx) bad = {bad, " load_tx"};
      if (got.tx_byte !== want.tx_byte) bad = {bad, " tx_byte"};
      if (got.release_bus !== want.release_bus) bad = {bad, " release_bus"};
      if (got.rd_valid !== want.rd_valid) bad = {bad, " rd_valid"};
      if (got.rd_index !== want.rd_index) bad = {bad, " rd_index"};
      if (got.rd_byte !== want.rd_byte) bad = {bad, " rd_byte"};
      if (got.pending !== want.pending) bad = {bad, " pending"};
      if (got.poll_event !== want.poll_event) bad = {bad, " poll_event"};
      if (got.last_status !== want.last_status) bad = {bad, " last_status"};
      if (pad !== 1'b0) bad = {bad, " pad"};
      if (bad != "") begin
        errors++;
        if (errors <= 10)
          $display("Result %0d mismatch in%s: expected %h, got %h pad %b",
                   n_results, bad, want, got, pad);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cmd_q.push_back(expected_commands(drv_item));
        items_in++;
        drv_busy = 1'b0;
      end
      if (!drv_busy && req_q.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          drv_item = req_q.pop_front();
          drv_busy = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= drv_busy;
      in_tuser <= drv_item.op;
      in_tdata <= {drv_item.rx_data, drv_item.bus_status, drv_item.load_byte,
                   drv_item.load_index, drv_item.read_count, drv_item.write_count,
                   drv_item.access_mode, drv_item.dev_addr};
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_result(i2cmts_pkg::out_item_t'(out_tdata[38:0]), out_tdata[39]);
      cyc_cnt++;
      if (cyc_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
      end else if (n_results >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 700;
      end
      case (stall_mode)
        0: out_tready <= (hold_left == 0);
        1: out_tready <= (hold_left == 0) && ($urandom_range(0, 1) == 0);
        2: out_tready <= (hold_left == 0) && (cyc_cnt % 5 < 3);
        default: out_tready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic i2cmts_pkg::in_item_t rand_item(input i2cmts_pkg::op_t op);
    i2cmts_pkg::in_item_t it;
    it.op = op;
    it.dev_addr = 7'($urandom);
    it.access_mode = 3'($urandom);
    it.write_count = 5'($urandom_range(0, 16));
    it.read_count = 5'($urandom_range(0, 16));
    it.load_index = 4'($urandom);
    it.load_byte = 8'($urandom);
    it.bus_status = 8'($urandom);
    it.rx_data = 8'($urandom);
    return it;
  endfunction

  task automatic push(input i2cmts_pkg::in_item_t it);
    req_q.push_back(it);
    pushed++;
  endtask

  task automatic push_status(input logic [7:0] code);
    i2cmts_pkg::in_item_t it;
    if (!cut) begin
      if ($urandom_range(0, 15) == 0) push(rand_item(i2cmts_pkg::OP_POLL));
      it = rand_item(i2cmts_pkg::OP_STATUS);
      it.bus_status = code;
      push(it);
      if ($urandom_range(0, 79) == 0) cut = 1'b1;
    end
  endtask

  task automatic push_polls(input int n);
    repeat (n) push(rand_item(i2cmts_pkg::OP_POLL));
  endtask

  task automatic push_transfer();
    i2cmts_pkg::in_item_t it;
    int       wc;
    int       rc;
    cut = 1'b0;
    wc = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    rc = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push(rand_item(i2cmts_pkg::OP_LOAD));
    it = rand_item(i2cmts_pkg::OP_START);
    it.write_count = 5'(wc);
    it.read_count = 5'(rc);
    push(it);
    push_status(i2cmts_pkg::ST_START);
    if ($urandom_range(0, 9) == 0) begin
      push_status(i2cmts_pkg::ST_ARB_LOST);
      push_status(i2cmts_pkg::ST_START);
    end
    if (it.access_mode[i2cmts_pkg::PF_WRITE]) begin
      push_status(i2cmts_pkg::ST_MT_SLA_ACK);
      repeat (wc) push_status(i2cmts_pkg::ST_MT_DATA_ACK);
      if (it.access_mode[i2cmts_pkg::PF_READ]) push_status(i2cmts_pkg::ST_REP_START);
    end
    if (it.access_mode[i2cmts_pkg::PF_READ] || !it.access_mode[i2cmts_pkg::PF_WRITE]) begin
      push_status(i2cmts_pkg::ST_MR_SLA_ACK);
      repeat ((rc > 1) ? rc - 1 : 0) push_status(i2cmts_pkg::ST_MR_DATA_ACK);
      push_status(i2cmts_pkg::ST_MR_DATA_NACK);
    end
  endtask

  task automatic push_noise();
    i2cmts_pkg::in_item_t it;
    it = rand_item(i2cmts_pkg::op_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 1) == 0) it.bus_status = KNOWN_CODES[$urandom_range(0, 7)];
    push(it);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || drv_busy) @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= TIMEOUT_ADDR;
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    timeout_val = value;
    settings++;
  endtask

  task automatic run_traffic(input int n);
    int first;
    first = pushed;
    while (pushed - first < n) begin
      wait_drained();
      if (flags[i2cmts_pkg::PF_ERROR] && timeout_val != '0) begin
        push_polls(256 - int'(ticks));
        recoveries++;
      end else if ($urandom_range(0, 9) == 0) begin
        push_noise();
      end else begin
        push_transfer();
      end
    end
  endtask

  initial begin
    i2cmts_pkg::in_item_t it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every buffer slot first so that no transmit ever reads an unwritten entry.
    for (int i = 0; i < i2cmts_pkg::BUF_DEPTH; i++) begin
      it = rand_item(i2cmts_pkg::OP_LOAD);
      it.load_index = 4'(i);
      it.load_byte = 8'(i * 17);
      push(it);
    end
    it = rand_item(i2cmts_pkg::OP_START);
    it.dev_addr = 7'h7F;
    it.access_mode = 3'd0;
    it.write_count = 5'd0;
    it.read_count = 5'd0;
    push(it);
    it = rand_item(i2cmts_pkg::OP_STATUS);
    it.bus_status = i2cmts_pkg::ST_START;
    push(it);
    it.bus_status = i2cmts_pkg::ST_MR_SLA_ACK;
    push(it);
    it.bus_status = i2cmts_pkg::ST_MR_DATA_ACK;
    it.rx_data = 8'hFF;
    push(it);
    it.bus_status = i2cmts_pkg::ST_MR_DATA_NACK;
    it.rx_data = 8'h00;
    push(it);
    it.bus_status = i2cmts_pkg::ST_ARB_LOST;
    push(it);
    it.bus_status = 8'hFF;
    push(it);
    it = rand_item(i2cmts_pkg::OP_START);
    it.dev_addr = 7'h00;
    it.access_mode = 3'd7;
    push(it);
    push(rand_item(i2cmts_pkg::OP_POLL));

    run_traffic(PHASE_ITEMS + 100);
    wait_idle();
    write_timeout(8'd1);
    run_traffic(PHASE_ITEMS);
    wait_idle();
    write_timeout(8'd255);
    run_traffic(PHASE_ITEMS);
    wait_idle();

    // A zero timeout matches at the counter wrap, so the timeout wins over the clear.
    write_timeout(8'd0);
    it = rand_item(i2cmts_pkg::OP_START);
    it.access_mode = 3'd7;
    push(it);
    wait_drained();
    push_polls(256 - int'(ticks));
    wait_idle();

    write_timeout(8'd255);
    run_traffic(PHASE_ITEMS);
    wait_idle();
    write_timeout(8'($urandom_range(2, 254)));
    run_traffic(PHASE_ITEMS);

    wait_drained();
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d items and %0d results over %0d timeout settings", items_in,
             n_results, settings);
    $display("Error recoveries by poll wrap: %0d, mismatches: %0d", recoveries, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/i2cmts_pkg.sv
sv/i2cmts_cfg.sv
sv/i2cmts_in_reg.sv
sv/i2cmts_core.sv
sv/i2cmts_out_reg.sv
sv/i2c_master_transaction_sequencer_unit.sv
verif/tb_top.sv
